// ----- design/ddo_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the
// differential-drive odometry core. No dependencies.
package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_W         = 34;

   typedef logic signed [15:0]         speed_type;
   typedef logic [15:0]                period_type;
   typedef logic signed [23:0]         rate_type;
   typedef logic signed [31:0]         pos_type;
   typedef logic [31:0]                angle_type;
   typedef logic [23:0]                inv_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;

   // 1/0.401 m in 2^-16 per metre
   localparam inv_type          INV_BASELINE_RESET = 24'd163431;
   // 2^32 / (2 pi) scaled, rad to binary angle
   localparam logic [29:0]      TURN_TO_ANGLE      = 30'd683565276;
   localparam cordic_type       CORDIC_GAIN        = 34'sd652032875;

   function automatic angle_type atan_angle(input logic [4:0] idx);
      case (idx)
         5'd0:  return 32'h20000000;
         5'd1:  return 32'h12E4051E;
         5'd2:  return 32'h09FB385B;
         5'd3:  return 32'h051111D4;
         5'd4:  return 32'h028B0D43;
         5'd5:  return 32'h0145D7E1;
         5'd6:  return 32'h00A2F61E;
         5'd7:  return 32'h00517C55;
         5'd8:  return 32'h0028BE53;
         5'd9:  return 32'h00145F2F;
         5'd10: return 32'h000A2F98;
         5'd11: return 32'h000517CC;
         5'd12: return 32'h00028BE6;
         5'd13: return 32'h000145F3;
         5'd14: return 32'h0000A2FA;
         5'd15: return 32'h0000517D;
         5'd16: return 32'h000028BE;
         5'd17: return 32'h0000145F;
         5'd18: return 32'h00000A30;
         5'd19: return 32'h00000518;
         5'd20: return 32'h0000028C;
         5'd21: return 32'h00000146;
         5'd22: return 32'h000000A3;
         5'd23: return 32'h00000051;
         5'd24: return 32'h00000029;
         5'd25: return 32'h00000014;
         5'd26: return 32'h0000000A;
         5'd27: return 32'h00000005;
         5'd28: return 32'h00000003;
         5'd29: return 32'h00000001;
         5'd30: return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

endpackage

// ----- design/ddo_req_if.sv -----
// Input channel: wheel speeds and sample period.
// Depends on ddo_pkg.
interface ddo_req_if;
   import ddo_pkg::*;
   logic       valid;
   logic       ready;
   speed_type  left_speed;
   speed_type  right_speed;
   period_type period;
   modport source (output valid, left_speed, right_speed, period, input ready);
   modport sink   (input valid, left_speed, right_speed, period, output ready);
endinterface

// ----- design/ddo_rsp_if.sv -----
// Result channel: velocities, turn rate and pose.
// Depends on ddo_pkg.
interface ddo_rsp_if;
   import ddo_pkg::*;
   logic      valid;
   logic      ready;
   speed_type vel_x;
   speed_type vel_y;
   rate_type  turn_rate;
   pos_type   pos_x;
   pos_type   pos_y;
   angle_type heading;
   modport source (output valid, vel_x, vel_y, turn_rate, pos_x, pos_y, heading,
                   input ready);
   modport sink   (input valid, vel_x, vel_y, turn_rate, pos_x, pos_y, heading,
                   output ready);
endinterface

// ----- design/ddo_csr_if.sv -----
// Configuration write channel for the inverse wheel base register.
// Depends on ddo_pkg.
interface ddo_csr_if;
   import ddo_pkg::*;
   logic    valid;
   logic    ready;
   inv_type inv_baseline;
   modport source (output valid, inv_baseline, input ready);
   modport sink   (input valid, inv_baseline, output ready);
endinterface

// ----- design/ddo_cordic.sv -----
// Iterative rotation-mode CORDIC: one micro-rotation per cycle through a
// shared add/shift unit. Depends on ddo_pkg.
module ddo_cordic #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ddo_pkg::angle_type   angle,
   output logic                 done,
   output ddo_pkg::cordic_type  cos_out,
   output ddo_pkg::cordic_type  sin_out
);
   import ddo_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);

   typedef enum logic [1:0] {CS_IDLE, CS_ITER, CS_FIX} cor_state_type;

   cor_state_type state_ff;
   logic [IW-1:0] step_ff;
   cordic_type    x_ff, y_ff, z_ff;
   cordic_type    x_in, y_in, z_in;
   cordic_type    dx, dy, at;
   cordic_type    cos_ff, sin_ff;
   logic          flip_ff, done_ff;
   logic          flip;
   angle_type     folded;

   // quadrants two and three fold onto one and four by a half turn
   assign flip   = angle[31] ^ angle[30];
   assign folded = {angle[31] ^ flip, angle[30:0]};

   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      at = $signed({2'b00, atan_angle(5'(step_ff))});
      if (!z_ff[CORDIC_W-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            CS_IDLE: begin
               if (start) begin
                  x_ff     <= CORDIC_GAIN;
                  y_ff     <= '0;
                  z_ff     <= {{(CORDIC_W-32){folded[31]}}, folded};
                  flip_ff  <= flip;
                  step_ff  <= '0;
                  state_ff <= CS_ITER;
               end
            end
            CS_ITER: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == IW'(CORDIC_STEPS - 1)) begin
                  state_ff <= CS_FIX;
               end
            end
            CS_FIX: begin
               cos_ff   <= flip_ff ? -x_ff : x_ff;
               sin_ff   <= flip_ff ? -y_ff : y_ff;
               done_ff  <= 1'b1;
               state_ff <= CS_IDLE;
            end
            default: state_ff <= CS_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

`ifndef SYNTH
   a_done_after_fix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == CS_FIX)
      else $error("cordic done without final step");
`endif

endmodule

// ----- design/diff_drive_odometry_core.sv -----
// Differential-drive odometry: heading, CORDIC resolve and pose integration.
// A new item is taken only once the previous one is through; the pace is set by the shared
// 34x31 multiplier sequence and the CORDIC, and a held result stalls only the final step.
// Reset: pose and heading cleared, inv_baseline back to 163431 (0.401 m base).
// Depends on ddo_pkg, ddo_req_if, ddo_rsp_if, ddo_csr_if and ddo_cordic.
module diff_drive_odometry_core #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input logic        clock,
   input logic        reset,
   ddo_req_if.sink    req_if,
   ddo_rsp_if.source  rsp_if,
   ddo_csr_if.sink    csr_if
);
   import ddo_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_W, ST_T, ST_M, ST_KH, ST_KL, ST_INC, ST_HEAD,
      ST_ROT, ST_WAIT, ST_FX, ST_FY, ST_PX, ST_PY, ST_DONE
   } state_type;

   state_type          state_ff;
   inv_type            inv_ff;
   pos_type            pos_x_ff, pos_y_ff;
   angle_type          heading_ff;
   logic signed [16:0] sum_ff, diff_ff;
   period_type         per_ff;
   logic signed [24:0] w_ff;
   logic [25:0]        m_ff;
   logic [47:0]        ahi_ff;
   angle_type          inc_ff;
   logic signed [33:0] fx_ff, fy_ff;
   logic signed [64:0] prod_ff;
   logic               rsp_valid_ff;
   speed_type          vel_x_ff, vel_y_ff;
   rate_type           turn_rate_ff;
   pos_type            rsp_pos_x_ff, rsp_pos_y_ff;
   angle_type          rsp_heading_ff;

   logic signed [33:0] mul_a;
   logic signed [30:0] mul_b;
   logic [16:0]        absd;
   logic [47:0]        inc_sum;
   logic signed [32:0] pos_sum;
   logic               rsp_load;
   logic               cor_start, cor_done;
   cordic_type         cor_cos, cor_sin;

   function automatic speed_type sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) return 16'sh7FFF;
      else if (v < -18'sd32768) return 16'sh8000;
      else return v[15:0];
   endfunction

   function automatic rate_type sat24(input logic signed [24:0] v);
      if (v > 25'sd8388607) return 24'sh7FFFFF;
      else if (v < -25'sd8388608) return 24'sh800000;
      else return v[23:0];
   endfunction

   function automatic pos_type sat32(input logic signed [32:0] v);
      if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -33'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

   ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (heading_ff),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign cor_start = (state_ff == ST_ROT);
   assign absd      = diff_ff[16] ? 17'(-diff_ff) : diff_ff;
   assign inc_sum   = ahi_ff + {18'b0, prod_ff[55:26]};
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      if (state_ff == ST_PY) pos_sum = 33'(pos_x_ff) + 33'($signed(prod_ff[50:26]));
      else                   pos_sum = 33'(pos_y_ff) + 33'($signed(prod_ff[50:26]));
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_W: begin
            mul_a = 34'(diff_ff);
            mul_b = $signed({7'b0, inv_ff});
         end
         ST_T: begin
            mul_a = $signed({18'b0, absd[15:0]});
            mul_b = $signed({15'b0, per_ff});
         end
         ST_M: begin
            mul_a = $signed({2'b0, prod_ff[31:0]});
            mul_b = $signed({7'b0, inv_ff});
         end
         ST_KH: begin
            mul_a = $signed({4'b0, prod_ff[55:26]});
            mul_b = $signed({1'b0, TURN_TO_ANGLE});
         end
         ST_KL: begin
            mul_a = $signed({8'b0, m_ff});
            mul_b = $signed({1'b0, TURN_TO_ANGLE});
         end
         ST_FX: begin
            mul_a = cor_cos;
            mul_b = 31'(sum_ff);
         end
         ST_FY: begin
            mul_a = cor_sin;
            mul_b = 31'(sum_ff);
         end
         ST_PX: begin
            mul_a = fx_ff;
            mul_b = $signed({15'b0, per_ff});
         end
         ST_PY: begin
            mul_a = fy_ff;
            mul_b = $signed({15'b0, per_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff != ST_DONE) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         inv_ff       <= INV_BASELINE_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
      end else begin
         if (csr_if.valid) begin
            inv_ff <= csr_if.inv_baseline;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  sum_ff   <= 17'(req_if.left_speed) + 17'(req_if.right_speed);
                  diff_ff  <= 17'(req_if.right_speed) - 17'(req_if.left_speed);
                  per_ff   <= req_if.period;
                  state_ff <= ST_W;
               end
            end
            ST_W:  state_ff <= ST_T;
            ST_T: begin
               w_ff     <= prod_ff[40:16];
               state_ff <= ST_M;
            end
            ST_M:  state_ff <= ST_KH;
            ST_KH: begin
               m_ff     <= prod_ff[25:0];
               state_ff <= ST_KL;
            end
            ST_KL: begin
               ahi_ff   <= prod_ff[47:0];
               state_ff <= ST_INC;
            end
            ST_INC: begin
               inc_ff   <= inc_sum[47:16];
               state_ff <= ST_HEAD;
            end
            ST_HEAD: begin
               heading_ff <= w_ff[24] ? heading_ff - inc_ff : heading_ff + inc_ff;
               state_ff   <= ST_ROT;
            end
            ST_ROT: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (cor_done) state_ff <= ST_FX;
            end
            ST_FX: state_ff <= ST_FY;
            ST_FY: begin
               fx_ff    <= prod_ff[48:15];
               state_ff <= ST_PX;
            end
            ST_PX: begin
               fy_ff    <= prod_ff[48:15];
               state_ff <= ST_PY;
            end
            ST_PY: begin
               pos_x_ff <= sat32(pos_sum);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  pos_y_ff       <= sat32(pos_sum);
                  rsp_pos_x_ff   <= pos_x_ff;
                  rsp_pos_y_ff   <= sat32(pos_sum);
                  rsp_heading_ff <= heading_ff;
                  vel_x_ff       <= sat16(fx_ff[33:16]);
                  vel_y_ff       <= sat16(fy_ff[33:16]);
                  turn_rate_ff   <= sat24(w_ff);
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.vel_x     = vel_x_ff;
   assign rsp_if.vel_y     = vel_y_ff;
   assign rsp_if.turn_rate = turn_rate_ff;
   assign rsp_if.pos_x     = rsp_pos_x_ff;
   assign rsp_if.pos_y     = rsp_pos_y_ff;
   assign rsp_if.heading   = rsp_heading_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("item taken while sequence running");

   a_cordic_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> state_ff == ST_WAIT)
      else $error("cordic result outside wait state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside final step");
`endif

endmodule
